// ===== rtl/fitness_merge_sorter_assert.svh =====
// Assertion macros shared by the fitness merge sorter checkers.
`ifndef FITNESS_MERGE_SORTER_ASSERT_SVH
`define FITNESS_MERGE_SORTER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define FMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fms_pkg.sv =====
// Package: sizes, payload types, controller interface and key conversion for the sorter.
`timescale 1ns / 1ps

package fms_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_BITS  = 32;
  localparam int TAG_BITS  = 16;
  localparam int FIT_BITS  = 32;

  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CW        = $clog2(MAX_ITEMS + 1);
  localparam int WW        = CW + 1;
  localparam int SW        = WW + 2;
  localparam int XW        = (KEY_BITS > FIT_BITS) ? KEY_BITS : FIT_BITS;
  localparam int SLOT_BITS = TAG_BITS + KEY_BITS;

  localparam logic signed [XW-1:0] KEY_MAX_X =
    {{(XW - KEY_BITS + 1){1'b0}}, {(KEY_BITS - 1){1'b1}}};
  localparam logic signed [XW-1:0] KEY_MIN_X =
    {{(XW - KEY_BITS + 1){1'b1}}, {(KEY_BITS - 1){1'b0}}};

  typedef struct packed {
    logic [TAG_BITS-1:0]        item_tag;
    logic signed [FIT_BITS-1:0] item_fitness;
    logic                       batch_end;
  } item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]        sorted_tag;
    logic signed [FIT_BITS-1:0] sorted_fitness;
    logic                       run_end;
    logic                       overflowed;
  } result_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]        tag;
    logic signed [KEY_BITS-1:0] key;
  } slot_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_init;
    logic merge_step;
    logic emit_init;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic batch_end;
    logic more;
    logic merge_last;
    logic emit_last;
    logic out_free;
  } status_t;

  // Saturate an input fitness into the stored key range.
  function automatic logic signed [KEY_BITS-1:0] fit_to_key(
    input logic signed [FIT_BITS-1:0] fit
  );
    logic signed [XW-1:0]       wide;
    logic signed [KEY_BITS-1:0] key;
    wide = XW'(fit);
    if (wide > KEY_MAX_X) begin
      key = KEY_MAX_X[KEY_BITS-1:0];
    end else if (wide < KEY_MIN_X) begin
      key = KEY_MIN_X[KEY_BITS-1:0];
    end else begin
      key = wide[KEY_BITS-1:0];
    end
    return key;
  endfunction

  // Bring a stored key back to the output fitness width.
  function automatic logic signed [FIT_BITS-1:0] key_to_fit(
    input logic signed [KEY_BITS-1:0] key
  );
    logic signed [XW-1:0] wide;
    wide = XW'(key);
    return wide[FIT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/fitness_merge_sorter.sv =====
// Fitness merge sorter: loads a batch, merge-sorts it by fitness and streams it out.
//
// Input channel (item_valid / item_stall / item): one transaction per individual,
// tag plus signed Q16.16 fitness; batch_end marks the last one. Input is never
// stalled while loading; items beyond 64 are dropped and mark the batch overflowed.
// After batch_end the block stalls its input and sorts with bottom-up merge passes
// over two ping-pong RAMs, one entry per cycle through the dual-read port.
// After the last pass the read of the first result is primed, then the results
// are emitted one by one.
// Output channel (result_valid / result_stall / result): one registered
// transaction per entry in sorted order, run_end on the last. A stall on the
// output holds the current result and pauses emission; input is taken again once
// the last result has been handed to the output register.
// cfg_we / cfg_wdata set the sort direction (1 highest first); write it only idle.
// Reset (rst, synchronous) empties the batch and selects highest first.
`timescale 1ns / 1ps

module fitness_merge_sorter (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  fms_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output fms_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  fms_pkg::cmd_t    cmd;
  fms_pkg::status_t status;

  fms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  fms_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/fms_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module fms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/fms_ctrl.sv =====
// Controller: sequences load, merge passes and emission of one batch.
`timescale 1ns / 1ps

module fms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  fms_pkg::status_t  status,
  output fms_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_EMIT0 = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_stall = 1'b1;
    unique case (state)
      S_LOAD: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (status.batch_end) begin
            cmd.sort_init = 1'b1;
            state_next    = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (status.more) begin
          cmd.pass_init = 1'b1;
          state_next    = S_MERGE;
        end else begin
          state_next = S_EMIT0;
        end
      end
      S_MERGE: begin
        cmd.merge_step = 1'b1;
        if (status.merge_last) begin
          state_next = S_PASS;
        end
      end
      S_EMIT0: begin
        cmd.emit_init = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.emit_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/fms_dp.sv =====
// Datapath: entry and scratch RAMs, merge pointers, key compare and output register.
`timescale 1ns / 1ps

module fms_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  fms_pkg::item_t    item,
  input  fms_pkg::cmd_t     cmd,
  output fms_pkg::status_t  status,
  output logic              result_valid,
  input  logic              result_stall,
  output fms_pkg::result_t  result
);

  logic                     descending;
  logic [fms_pkg::CW-1:0]   count, count_next;
  logic                     dropped, dropped_next;
  logic [fms_pkg::WW-1:0]   width, width_next;
  logic                     src_sel, src_sel_next;
  logic [fms_pkg::CW-1:0]   a, a_next;
  logic [fms_pkg::CW-1:0]   b, b_next;
  logic [fms_pkg::CW-1:0]   mid, mid_next;
  logic [fms_pkg::CW-1:0]   hi, hi_next;
  logic [fms_pkg::CW-1:0]   k, k_next;
  logic                     result_valid_next;
  fms_pkg::result_t         result_next;

  logic [fms_pkg::SLOT_BITS-1:0] r0a, r0b, r1a, r1b;
  logic [fms_pkg::SLOT_BITS-1:0] wdata0;
  logic [fms_pkg::AW-1:0]        waddr0;
  logic                          we0, we1;
  fms_pkg::slot_t                ra, rb, win, load_slot;

  logic                   not_full;
  logic                   a_live, b_live, right_first, take_b;
  logic [fms_pkg::CW-1:0] k_inc, a_inc;
  logic [fms_pkg::SW-1:0] w_s, n_s, hi_s, sum_mid, sum_hi, grp_mid, grp_hi, init_mid, init_hi;

  fms_ram #(.WIDTH(fms_pkg::SLOT_BITS), .DEPTH(fms_pkg::MAX_ITEMS)) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (a_next[fms_pkg::AW-1:0]),
    .raddr_b (b_next[fms_pkg::AW-1:0]),
    .rdata_a (r0a),
    .rdata_b (r0b)
  );

  fms_ram #(.WIDTH(fms_pkg::SLOT_BITS), .DEPTH(fms_pkg::MAX_ITEMS)) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (k[fms_pkg::AW-1:0]),
    .wdata   (win),
    .raddr_a (a_next[fms_pkg::AW-1:0]),
    .raddr_b (b_next[fms_pkg::AW-1:0]),
    .rdata_a (r1a),
    .rdata_b (r1b)
  );

  always_comb begin
    ra = fms_pkg::slot_t'(src_sel ? r1a : r0a);
    rb = fms_pkg::slot_t'(src_sel ? r1b : r0b);

    load_slot.tag = item.item_tag;
    load_slot.key = fms_pkg::fit_to_key(item.item_fitness);

    not_full = count < fms_pkg::CW'(fms_pkg::MAX_ITEMS);

    // Stable merge: the right run goes first only on a strict win.
    a_live      = a < mid;
    b_live      = b < hi;
    right_first = descending ? (rb.key > ra.key) : (rb.key < ra.key);
    take_b      = b_live && (!a_live || right_first);
    win         = take_b ? rb : ra;

    k_inc = k + fms_pkg::CW'(1);
    a_inc = a + fms_pkg::CW'(1);

    w_s      = fms_pkg::SW'(width);
    n_s      = fms_pkg::SW'(count);
    hi_s     = fms_pkg::SW'(hi);
    sum_mid  = hi_s + w_s;
    sum_hi   = hi_s + (w_s << 1);
    grp_mid  = (sum_mid < n_s) ? sum_mid : n_s;
    grp_hi   = (sum_hi < n_s) ? sum_hi : n_s;
    init_mid = (w_s < n_s) ? w_s : n_s;
    init_hi  = ((w_s << 1) < n_s) ? (w_s << 1) : n_s;

    status.batch_end  = item.batch_end;
    status.more       = fms_pkg::SW'(width) < n_s;
    status.merge_last = k_inc == count;
    status.emit_last  = a_inc == count;
    status.out_free   = !result_valid || !result_stall;

    we0    = (cmd.load && not_full) || (cmd.merge_step && src_sel);
    we1    = cmd.merge_step && !src_sel;
    waddr0 = cmd.load ? count[fms_pkg::AW-1:0] : k[fms_pkg::AW-1:0];
    wdata0 = cmd.load ? load_slot : win;
  end

  always_comb begin
    count_next        = count;
    dropped_next      = dropped;
    width_next        = width;
    src_sel_next      = src_sel;
    a_next            = a;
    b_next            = b;
    mid_next          = mid;
    hi_next           = hi;
    k_next            = k;
    result_valid_next = result_valid;
    result_next       = result;

    if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end

    if (cmd.load) begin
      if (not_full) begin
        count_next = count + fms_pkg::CW'(1);
      end else begin
        dropped_next = 1'b1;
      end
    end

    if (cmd.sort_init) begin
      width_next   = fms_pkg::WW'(1);
      src_sel_next = 1'b0;
    end

    if (cmd.pass_init) begin
      a_next   = '0;
      mid_next = fms_pkg::CW'(init_mid);
      b_next   = fms_pkg::CW'(init_mid);
      hi_next  = fms_pkg::CW'(init_hi);
      k_next   = '0;
    end

    if (cmd.merge_step) begin
      k_next = k_inc;
      if (take_b) begin
        b_next = b + fms_pkg::CW'(1);
      end else begin
        a_next = a_inc;
      end
      // Advance to the next pair of runs once this one is filled.
      if (k_inc == hi) begin
        a_next   = hi;
        mid_next = fms_pkg::CW'(grp_mid);
        b_next   = fms_pkg::CW'(grp_mid);
        hi_next  = fms_pkg::CW'(grp_hi);
      end
      if (k_inc == count) begin
        width_next   = width << 1;
        src_sel_next = ~src_sel;
      end
    end

    if (cmd.emit_init) begin
      a_next = '0;
    end

    if (cmd.emit_step) begin
      a_next                     = a_inc;
      result_valid_next          = 1'b1;
      result_next.sorted_tag     = ra.tag;
      result_next.sorted_fitness = fms_pkg::key_to_fit(ra.key);
      result_next.run_end        = status.emit_last;
      result_next.overflowed     = dropped;
      if (status.emit_last) begin
        count_next   = '0;
        dropped_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descending   <= 1'b1;
      count        <= '0;
      dropped      <= 1'b0;
      width        <= '0;
      src_sel      <= 1'b0;
      a            <= '0;
      b            <= '0;
      mid          <= '0;
      hi           <= '0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        descending <= cfg_wdata;
      end
      count        <= count_next;
      dropped      <= dropped_next;
      width        <= width_next;
      src_sel      <= src_sel_next;
      a            <= a_next;
      b            <= b_next;
      mid          <= mid_next;
      hi           <= hi_next;
      k            <= k_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== rtl/fms_checker.sv =====
// Port checker for the fitness merge sorter, bound to the top level.
`timescale 1ns / 1ps
`include "fitness_merge_sorter_assert.svh"

module fms_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input fms_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input fms_pkg::result_t result
);

  `FMS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
  `FMS_ASSERT_NEXT(a_sort_stalls_input, item_valid && !item_stall && item.batch_end, item_stall, "input not stalled after batch end")
  `FMS_ASSERT_SAME(a_emit_stalls_input, result_valid && !result.run_end, item_stall, "input taken mid batch output")

endmodule

bind fitness_merge_sorter fms_checker u_fms_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== dv/fms_sort_checker.sv =====
// Checker for the fitness merge sorter: predicts sorted batches and compares results.
`timescale 1ns / 1ps

module fms_sort_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  fms_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  fms_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output int               mismatches,
  output int               awaiting,
  output int               results_checked
);

  typedef struct {
    logic [fms_pkg::TAG_BITS-1:0] tag;
    longint                       key;
  } held_t;

  held_t            batch [fms_pkg::MAX_ITEMS];
  int unsigned      held_count;
  bit               held_dropped;
  bit               highest_first;
  fms_pkg::result_t due_results [$];

  task automatic log_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Clamp the incoming fitness to the signed range of a stored key.
  function automatic longint clamp_to_key(
    input logic signed [fms_pkg::FIT_BITS-1:0] fit
  );
    longint v;
    longint key_hi;
    longint key_lo;
    v      = fit;
    key_hi = (longint'(1) <<< (fms_pkg::KEY_BITS - 1)) - 1;
    key_lo = -key_hi - 1;
    if (v > key_hi) v = key_hi;
    if (v < key_lo) v = key_lo;
    return v;
  endfunction

  // Strict order only, so equal keys never pass each other.
  function automatic bit outranks(input held_t a, input held_t b);
    return highest_first ? (a.key > b.key) : (a.key < b.key);
  endfunction

  task automatic rank_batch();
    held_t            cur;
    int               j;
    longint           wide;
    fms_pkg::result_t r;
    for (int i = 1; i < int'(held_count); i++) begin
      cur = batch[i];
      j   = i;
      while (j > 0 && outranks(cur, batch[j-1])) begin
        batch[j] = batch[j-1];
        j--;
      end
      batch[j] = cur;
    end
    for (int k = 0; k < int'(held_count); k++) begin
      wide             = batch[k].key;
      r.sorted_tag     = batch[k].tag;
      r.sorted_fitness = wide[fms_pkg::FIT_BITS-1:0];
      r.run_end        = (k == int'(held_count) - 1);
      r.overflowed     = held_dropped;
      due_results.push_back(r);
    end
    held_count   = 0;
    held_dropped = 0;
  endtask

  task automatic absorb_item(input fms_pkg::item_t it);
    if (held_count < fms_pkg::MAX_ITEMS) begin
      batch[held_count].tag = it.item_tag;
      batch[held_count].key = clamp_to_key(it.item_fitness);
      held_count++;
    end else begin
      held_dropped = 1;
    end
    if (it.batch_end) rank_batch();
  endtask

  task automatic compare_result(input fms_pkg::result_t got);
    fms_pkg::result_t want;
    if (due_results.size() == 0) begin
      log_mismatch($sformatf("unexpected result tag %h fitness %h",
                             got.sorted_tag, got.sorted_fitness));
      return;
    end
    want = due_results.pop_front();
    results_checked++;
    if (got.sorted_tag !== want.sorted_tag)
      log_mismatch($sformatf("sorted_tag %h, want %h", got.sorted_tag, want.sorted_tag));
    if (got.sorted_fitness !== want.sorted_fitness)
      log_mismatch($sformatf("sorted_fitness %h, want %h (tag %h)",
                             got.sorted_fitness, want.sorted_fitness, want.sorted_tag));
    if (got.run_end !== want.run_end)
      log_mismatch($sformatf("run_end %b, want %b (tag %h)",
                             got.run_end, want.run_end, want.sorted_tag));
    if (got.overflowed !== want.overflowed)
      log_mismatch($sformatf("overflowed %b, want %b (tag %h)",
                             got.overflowed, want.overflowed, want.sorted_tag));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_results.delete();
      held_count      = 0;
      held_dropped    = 0;
      highest_first   = 1;
      mismatches      = 0;
      results_checked = 0;
    end else begin
      // Check the outgoing transaction first so a new batch cannot mask it.
      if (result_valid && !result_stall) compare_result(result);
      if (cfg_we) highest_first = cfg_wdata;
      if (item_valid && !item_stall) absorb_item(item);
    end
    awaiting = due_results.size();
  end

endmodule

// ===== dv/fitness_merge_sorter_tb.sv =====
// Testbench top for the fitness merge sorter: stimulus, idling mixes and verdict.
`timescale 1ns / 1ps

module fitness_merge_sorter_tb;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES   = 16;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  fms_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  fms_pkg::result_t result;
  logic             cfg_we       = 1'b0;
  logic             cfg_wdata    = 1'b0;

  int mismatches;
  int awaiting;
  int results_checked;
  int gap_pct;
  int stall_pct;
  int items_sent;
  int batches_sent;
  int overflow_batches;
  int idle_cycles;

  always #5 clk = ~clk;

  fitness_merge_sorter uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  fms_sort_checker sort_check (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked)
  );

  always @(negedge clk) begin
    result_stall = ($urandom_range(99) < stall_pct);
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fitness_merge_sorter verification failed");
      $finish;
    end
  end

  // Called right after a falling edge; returns just after a falling edge, once the item has been taken.
  task automatic present_item(input logic [fms_pkg::TAG_BITS-1:0] tag,
                              input logic [fms_pkg::FIT_BITS-1:0] fit, input bit last);
    while ($urandom_range(99) < gap_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid        = 1'b1;
    item.item_tag     = tag;
    item.item_fitness = fit;
    item.batch_end    = last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (last) batches_sent++;
    @(negedge clk);
  endtask

  task automatic write_direction(input bit highest_first);
    cfg_we    = 1'b1;
    cfg_wdata = highest_first;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mix full-range keys with a narrow band so ties show up often.
  function automatic logic [fms_pkg::FIT_BITS-1:0] random_fitness();
    case ($urandom_range(3))
      0: return $urandom();
      1: return (int'($urandom_range(6)) - 3) <<< 16;
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return {($urandom_range(1) ? 16'hFFFF : 16'h0000), 16'($urandom())};
    endcase
  endfunction

  function automatic int pick_batch_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return $urandom_range(1, 8);
    if (p < 82) return $urandom_range(9, 40);
    if (p < 95) return $urandom_range(fms_pkg::MAX_ITEMS - 4, fms_pkg::MAX_ITEMS);
    return $urandom_range(fms_pkg::MAX_ITEMS + 1, fms_pkg::MAX_ITEMS + 4);
  endfunction

  task automatic random_batch(input int len);
    if (len > fms_pkg::MAX_ITEMS) overflow_batches++;
    for (int i = 0; i < len; i++) begin
      present_item(16'($urandom()), random_fitness(), i == len - 1);
    end
  endtask

  logic [fms_pkg::TAG_BITS-1:0] edge_tags [7] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0001,
                                                  16'h0002, 16'hAAAA, 16'h5555};
  logic [fms_pkg::FIT_BITS-1:0] edge_fits [7] = '{32'h7FFF_FFFF, 32'h8000_0000,
                                                  32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h0000_0000, 32'h0001_0000,
                                                  32'h8000_0000};

  initial begin
    int  phase_items;
    bit  first_batch;
    int  len;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Extremes and ties in both directions, plus a one-entry batch.
    write_direction(1'b1);
    for (int i = 0; i < 7; i++) present_item(edge_tags[i], edge_fits[i], i == 6);
    present_item(16'hBEEF, 32'h0000_8000, 1'b1);
    drain();
    write_direction(1'b0);
    for (int i = 0; i < 7; i++) present_item(edge_tags[i], edge_fits[i], i == 6);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_direction(1'b0);
        1: write_direction(1'b1);
        default: write_direction(bit'($urandom_range(1)));
      endcase
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      phase_items = 0;
      first_batch = 1'b1;
      while (phase_items < ITEMS_PER_PHASE) begin
        // Open with a full store where the item carrying batch_end is dropped.
        len = (ph == 0 && first_batch) ? fms_pkg::MAX_ITEMS + 1 : pick_batch_len();
        random_batch(len);
        phase_items += len;
        first_batch  = 1'b0;
      end
    end

    drain();
    $display("Run covered %0d items in %0d batches, %0d of them past capacity,",
             items_sent, batches_sent, overflow_batches);
    $display("sorting both ways under four idling mixes; %0d sorted results checked.",
             results_checked);
    if (mismatches == 0 && awaiting == 0) begin
      $display("fitness_merge_sorter verification clean");
    end else begin
      $display("fitness_merge_sorter verification failed");
    end
    $finish;
  end

endmodule
